>>> src/hil_pkg.sv
package hil_pkg;

    localparam int MaxPixelsLog2 = 24;
    localparam int BinCount      = 256;
    localparam int BinW          = 8;
    localparam int PixW          = 16;
    localparam int FracW         = 16;
    localparam int CntW          = MaxPixelsLog2 + 1;
    localparam int SumW          = CntW + BinW;
    localparam int MulAW         = FracW + 1;
    localparam int ProdW         = MulAW + CntW;
    localparam int CmpW          = SumW + FracW;
    localparam int UpW           = PixW + 1;
    localparam int OutDataW      = ((PixW + UpW + 7) / 8) * 8;

    localparam logic [CntW-1:0]  CntMax       = {CntW{1'b1}};
    localparam logic [FracW-1:0] CumFracReset = 16'd655;
    localparam logic [FracW-1:0] BinFracReset = 16'd66;
    localparam logic [FracW-1:0] OffsetReset  = 16'd0;
    localparam logic [MulAW-1:0] FracOne      = 17'h10000;
    localparam logic [BinW-1:0]  LastBin      = BinW'(BinCount - 1);

    typedef enum logic [1:0] {
        CFG_CUM_FRAC = 2'd0,
        CFG_BIN_FRAC = 2'd1,
        CFG_LOW_OFFS = 2'd2
    } t_cfg_idx;

    typedef enum logic [10:0] {
        S_CLR  = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_PXWR = 11'b000_0000_0100,
        S_MLO  = 11'b000_0000_1000,
        S_MHI  = 11'b000_0001_0000,
        S_MSP  = 11'b000_0010_0000,
        S_MEND = 11'b000_0100_0000,
        S_RD   = 11'b000_1000_0000,
        S_ACC  = 11'b001_0000_0000,
        S_CMP  = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } t_state;

endpackage

>>> src/hil_mul.sv
module hil_mul (
    input  logic                         i_clk,
    input  logic [hil_pkg::MulAW-1:0]    i_a,
    input  logic [hil_pkg::CntW-1:0]     i_b,
    output logic [hil_pkg::ProdW-1:0]    o_p
);

    logic [hil_pkg::ProdW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= hil_pkg::ProdW'(i_a) * hil_pkg::ProdW'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> src/histogram_intensity_limits_top.sv
// Each pixel request reads its bin counter and writes it back through one RAM port; no new
// pixel is taken before the write back. The request carrying tlast then forms the three
// threshold products on the shared multiplier, scans the 256 bins (read, accumulate, compare)
// and finishes. After reset a clearing pass zeroes the bins before the first pixel is taken.
// Reset is synchronous and active low; it restores the register defaults and clears the control.
module histogram_intensity_limits_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [hil_pkg::PixW-1:0]         i_s_tdata,   // pixel
    input  logic                             i_s_tlast,   // last_pixel
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [hil_pkg::OutDataW-1:0]     o_m_tdata,   // lower_limit, upper_limit, zero pad
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [hil_pkg::FracW-1:0]        i_cfg_data
);

    hil_pkg::t_state r_state, n_state;

    logic [hil_pkg::FracW-1:0] r_cum_frac, r_bin_frac, r_low_offs;

    logic [hil_pkg::CntW-1:0]  r_mem [hil_pkg::BinCount];
    logic [hil_pkg::CntW-1:0]  r_rd_data;
    logic [hil_pkg::BinW-1:0]  w_addr;
    logic                      w_we;
    logic [hil_pkg::CntW-1:0]  w_wdata;

    logic [hil_pkg::BinW-1:0]  r_n, r_bin, r_lower, r_upper;
    logic                      r_last, r_found, r_sparse;
    logic [hil_pkg::CntW-1:0]  r_total;
    logic [hil_pkg::SumW-1:0]  r_rsum;
    logic [hil_pkg::ProdW-1:0] r_low_tail, r_high_tail, r_sparse_lim;

    logic [hil_pkg::MulAW-1:0] w_mul_a;
    logic [hil_pkg::ProdW-1:0] w_mul_p;

    logic                      r_out_valid;
    logic [hil_pkg::PixW-1:0]  r_out_lower;
    logic [hil_pkg::UpW-1:0]   r_out_upper;

    logic                      w_accept;
    logic [hil_pkg::CmpW-1:0]  w_rsum_sh;
    logic                      w_low_ok, w_high_ok;
    logic [hil_pkg::PixW-1:0]  w_lower_pix, w_lower_fin;
    logic [hil_pkg::UpW-1:0]   w_upper_fin;
    logic                      w_out_free;

    assign o_s_tready  = (r_state == hil_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cum_frac <= hil_pkg::CumFracReset;
            r_bin_frac <= hil_pkg::BinFracReset;
            r_low_offs <= hil_pkg::OffsetReset;
        end else if (i_cfg_valid) begin
            case (hil_pkg::t_cfg_idx'(i_cfg_index))
                hil_pkg::CFG_CUM_FRAC: r_cum_frac <= i_cfg_data;
                hil_pkg::CFG_BIN_FRAC: r_bin_frac <= i_cfg_data;
                hil_pkg::CFG_LOW_OFFS: r_low_offs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_addr  = r_n;
        w_we    = 1'b0;
        w_wdata = '0;
        case (r_state)
            hil_pkg::S_CLR: begin
                w_we = 1'b1;
            end
            hil_pkg::S_IDLE: begin
                w_addr = i_s_tdata[hil_pkg::PixW-1 -: hil_pkg::BinW];
            end
            hil_pkg::S_PXWR: begin
                w_addr  = r_bin;
                w_we    = 1'b1;
                w_wdata = (r_rd_data == hil_pkg::CntMax) ? r_rd_data
                                                         : r_rd_data + 1'b1;
            end
            hil_pkg::S_RD: begin
                w_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_addr];
    end

    always_comb begin
        case (r_state)
            hil_pkg::S_MHI: w_mul_a = hil_pkg::FracOne - hil_pkg::MulAW'(r_cum_frac);
            hil_pkg::S_MSP: w_mul_a = hil_pkg::MulAW'(r_bin_frac);
            default:        w_mul_a = hil_pkg::MulAW'(r_cum_frac);
        endcase
    end

    hil_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (r_total),
        .o_p   (w_mul_p)
    );

    assign w_rsum_sh = {r_rsum, {hil_pkg::FracW{1'b0}}};
    assign w_low_ok  = r_sparse && (w_rsum_sh <= hil_pkg::CmpW'(r_low_tail));
    assign w_high_ok = r_sparse && (w_rsum_sh >= hil_pkg::CmpW'(r_high_tail));

    assign w_lower_pix = {r_lower, {(hil_pkg::PixW - hil_pkg::BinW){1'b0}}};
    assign w_lower_fin = (w_lower_pix > r_low_offs) ? w_lower_pix - r_low_offs : '0;
    assign w_upper_fin = r_found
        ? {1'b0, r_upper, {(hil_pkg::PixW - hil_pkg::BinW){1'b0}}} - 1'b1
        : {1'b0, {hil_pkg::PixW{1'b1}}};

    always_comb begin
        n_state = r_state;
        case (r_state)
            hil_pkg::S_CLR:  if (r_n == hil_pkg::LastBin) n_state = hil_pkg::S_IDLE;
            hil_pkg::S_IDLE: if (w_accept) n_state = hil_pkg::S_PXWR;
            hil_pkg::S_PXWR: n_state = r_last ? hil_pkg::S_MLO : hil_pkg::S_IDLE;
            hil_pkg::S_MLO:  n_state = hil_pkg::S_MHI;
            hil_pkg::S_MHI:  n_state = hil_pkg::S_MSP;
            hil_pkg::S_MSP:  n_state = hil_pkg::S_MEND;
            hil_pkg::S_MEND: n_state = hil_pkg::S_RD;
            hil_pkg::S_RD:   n_state = hil_pkg::S_ACC;
            hil_pkg::S_ACC:  n_state = hil_pkg::S_CMP;
            hil_pkg::S_CMP:  n_state = (r_n == hil_pkg::LastBin) ? hil_pkg::S_FIN
                                                                 : hil_pkg::S_RD;
            hil_pkg::S_FIN:  if (w_out_free) n_state = hil_pkg::S_IDLE;
            default:         n_state = hil_pkg::S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hil_pkg::S_CLR;
            r_n         <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                hil_pkg::S_CLR: begin
                    r_n <= r_n + 1'b1;
                end
                hil_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_bin  <= i_s_tdata[hil_pkg::PixW-1 -: hil_pkg::BinW];
                        r_last <= i_s_tlast;
                        if (r_total != hil_pkg::CntMax) begin
                            r_total <= r_total + 1'b1;
                        end
                    end
                end
                hil_pkg::S_MHI: begin
                    r_low_tail <= w_mul_p;
                end
                hil_pkg::S_MSP: begin
                    r_high_tail <= w_mul_p;
                end
                hil_pkg::S_MEND: begin
                    r_sparse_lim <= w_mul_p;
                    r_total      <= '0;
                    r_rsum       <= '0;
                    r_lower      <= '0;
                    r_upper      <= '0;
                    r_found      <= 1'b0;
                    r_n          <= '0;
                end
                hil_pkg::S_ACC: begin
                    r_rsum   <= r_rsum + hil_pkg::SumW'(r_rd_data);
                    r_sparse <= hil_pkg::ProdW'({r_rd_data, {hil_pkg::FracW{1'b0}}})
                                <= r_sparse_lim;
                end
                hil_pkg::S_CMP: begin
                    if (!r_found) begin
                        if (w_low_ok) begin
                            r_lower <= r_n;
                        end
                        if (w_high_ok) begin
                            r_upper <= r_n;
                            r_found <= 1'b1;
                        end
                    end
                    r_n <= r_n + 1'b1;
                end
                hil_pkg::S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_lower <= w_lower_fin;
                        r_out_upper <= w_upper_fin;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(hil_pkg::OutDataW - hil_pkg::PixW - hil_pkg::UpW){1'b0}},
                         r_out_upper, r_out_lower};

endmodule
